// ----- sv/pac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants for the polygon area/centroid core
// Widths of the vertex and result fields, the accumulators and the divider,
// plus the request/response structs between the core and its divider.
// ----------------------------------------------------------------------------
package pac_pkg;

	localparam int COORD_W   = 16;                 // vertex coordinate width
	localparam int FRAC_BITS = 8;                  // centroid fraction bits
	localparam int ESUM_W    = COORD_W + 1;        // sum of two coordinates
	localparam int EDGE_W    = 2 * COORD_W + 1;    // one edge cross product
	localparam int PROD_W    = ESUM_W + EDGE_W;    // shared multiplier product
	localparam int CROSS_W   = 48;                 // contour cross sum
	localparam int SUM_W     = 64;                 // centroid term sums
	localparam int AREA_W    = 46;                 // twice-area total
	localparam int CEN_W     = 24;                 // centroid result
	localparam int DVD_W     = SUM_W + FRAC_BITS;  // scaled dividend
	localparam int DCNT_W    = $clog2(DVD_W);      // divider step counter

	localparam logic [AREA_W-1:0] AREA_MAX     = {AREA_W{1'b1}};
	localparam logic [CEN_W-1:0]  CEN_POS_MAX  = {1'b0, {(CEN_W-1){1'b1}}};
	localparam logic [CEN_W-1:0]  CEN_NEG_MAG  = {1'b1, {(CEN_W-1){1'b0}}};
	localparam logic [DCNT_W-1:0] DCNT_LAST    = DCNT_W'(DVD_W - 1);

	typedef struct packed {
		logic                      start;
		logic [SUM_W-1:0]          sum;
		logic [CROSS_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                      done;
		logic [CEN_W-1:0]          quo;
	} div_rsp_t;

endpackage

// ----- sv/pac_vertex_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_vertex_if: vertex input channel
// Valid/ready channel carrying one polygon vertex and its end marks.
// ----------------------------------------------------------------------------
interface pac_vertex_if;
	logic                               valid;
	logic                               ready;
	logic signed [pac_pkg::COORD_W-1:0] vertex_x;
	logic signed [pac_pkg::COORD_W-1:0] vertex_y;
	logic                               contour_end;
	logic                               shape_end;

	modport source (output valid, output vertex_x, output vertex_y,
		output contour_end, output shape_end, input ready);
	modport sink (input valid, input vertex_x, input vertex_y,
		input contour_end, input shape_end, output ready);
endinterface

// ----- sv/pac_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_result_if: shape result channel
// Valid/ready channel carrying twice-area, centroid and degenerate flag.
// ----------------------------------------------------------------------------
interface pac_result_if;
	logic                             valid;
	logic                             ready;
	logic [pac_pkg::AREA_W-1:0]       area_twice;
	logic signed [pac_pkg::CEN_W-1:0] centroid_x;
	logic signed [pac_pkg::CEN_W-1:0] centroid_y;
	logic                             degenerate;

	modport source (output valid, output area_twice, output centroid_x,
		output centroid_y, output degenerate, input ready);
	modport sink (input valid, input area_twice, input centroid_x,
		input centroid_y, input degenerate, output ready);
endinterface

// ----- sv/pac_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_div: serial fixed-point divider
// Restoring division of a signed 64-bit sum by an unsigned 48-bit divisor,
// one quotient bit per cycle, with the fraction bits appended to the dividend.
// The result is truncated toward zero and saturated to the signed range.
// ----------------------------------------------------------------------------
module pac_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pac_pkg::div_req_t req,
	output pac_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic                           neg_q;
	logic                           ovf_q;
	logic [pac_pkg::DCNT_W-1:0]     cnt_q;
	logic [pac_pkg::DVD_W-1:0]      dvd_q;
	logic [pac_pkg::CROSS_W-1:0]    rem_q;
	logic [pac_pkg::CEN_W-1:0]      quo_q;

	logic [pac_pkg::SUM_W-1:0]      mag;
	logic [pac_pkg::CROSS_W:0]      trial;
	logic [pac_pkg::CROSS_W:0]      diff;
	logic                           fits;
	logic [pac_pkg::CEN_W-1:0]      lim;
	logic [pac_pkg::CEN_W-1:0]      res_mag;

	assign mag   = req.sum[pac_pkg::SUM_W-1] ? (~req.sum + 1'b1) : req.sum;
	assign trial = {rem_q, dvd_q[pac_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, req.divisor};
	assign fits  = (trial >= {1'b0, req.divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			dvd_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.sum[pac_pkg::SUM_W-1];
				ovf_q  <= 1'b0;
				cnt_q  <= '0;
				dvd_q  <= {mag, {pac_pkg::FRAC_BITS{1'b0}}};
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				rem_q <= fits ? diff[pac_pkg::CROSS_W-1:0] : trial[pac_pkg::CROSS_W-1:0];
				quo_q <= {quo_q[pac_pkg::CEN_W-2:0], fits};
				// A set bit falling off the top means the quotient is already too big.
				ovf_q <= ovf_q | quo_q[pac_pkg::CEN_W-1];
				dvd_q <= {dvd_q[pac_pkg::DVD_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pac_pkg::DCNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign lim     = neg_q ? pac_pkg::CEN_NEG_MAG : pac_pkg::CEN_POS_MAX;
	assign res_mag = (ovf_q || (quo_q > lim)) ? lim : quo_q;

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? (~res_mag + 1'b1) : res_mag;

endmodule

// ----- sv/polygon_area_centroid_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_area_centroid_core: streaming shoelace area and centroid
// Accumulates polygon edges with one shared multiplier and gives, per shape,
// twice the area and the centroid in Q16.8 through a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   vtx carries one vertex per transfer with contour_end and shape_end marks;
//   shape_end closes the open contour as well. res carries one result per
//   shape, transferred after the last vertex of that shape.
//   Each edge runs through one shared 17x33 multiplier in six steps (two
//   products for the cross term, two for the centroid terms); a vertex that
//   opens a contour adds no edge, any other vertex adds its edge, and a
//   vertex that ends a contour adds the closing edge as well (only that one
//   if it is a contour on its own). At shape end a bit-serial divider runs
//   once for each centroid axis; a zero-area shape skips the divider.
//   vtx.ready is high only while the core waits for a vertex.
//   The result sits in an output register; the core keeps accepting vertices
//   while it waits, and only stalls at the next shape end if the receiver has
//   still not taken the previous result.
//   Reset clears all accumulators and the open contour.
// ----------------------------------------------------------------------------
module polygon_area_centroid_core (
	input  logic                clk,
	input  logic                arst_n,
	pac_vertex_if.sink          vtx,
	pac_result_if.source        res
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_E0,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_E4,
		ST_E5,
		ST_CLOSE,
		ST_SETUP,
		ST_DIVX,
		ST_DIVY,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic signed [pac_pkg::COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [pac_pkg::COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic                               in_contour_q;
	logic                               end_q;
	logic                               shape_q;
	logic                               closing_q;

	logic signed [pac_pkg::EDGE_W-1:0]  cross_q;
	logic signed [pac_pkg::ESUM_W-1:0]  xsum_q, ysum_q;
	logic signed [pac_pkg::PROD_W-1:0]  prod_q;

	logic [pac_pkg::CROSS_W-1:0]        ccross_q;
	logic [pac_pkg::SUM_W-1:0]          cx_q, cy_q;
	logic [pac_pkg::AREA_W-1:0]         tarea_q;
	logic [pac_pkg::SUM_W-1:0]          tx_q, ty_q;

	logic                               start_q;
	logic [pac_pkg::SUM_W-1:0]          div_sum_q;
	logic [pac_pkg::CROSS_W-1:0]        div_den_q;
	logic [pac_pkg::CEN_W-1:0]          cen_x_q, cen_y_q;
	logic                               degen_q;

	logic                               out_valid_q;
	logic [pac_pkg::AREA_W-1:0]         out_area_q;
	logic [pac_pkg::CEN_W-1:0]          out_cx_q, out_cy_q;
	logic                               out_degen_q;

	logic signed [pac_pkg::ESUM_W-1:0]  mul_a;
	logic signed [pac_pkg::EDGE_W-1:0]  mul_b;
	logic signed [pac_pkg::PROD_W-1:0]  mul_p;
	logic signed [pac_pkg::EDGE_W-1:0]  cross_next;

	logic                               c_neg;
	logic [pac_pkg::CROSS_W-1:0]        c_mag;
	logic [pac_pkg::CROSS_W:0]          area_sum;
	logic [pac_pkg::SUM_W-1:0]          cx_signed, cy_signed;

	pac_pkg::div_req_t                  div_req;
	pac_pkg::div_rsp_t                  div_rsp;

	// Shared multiplier operand selection.
	always_comb begin
		case (state_q)
			ST_E0: begin
				mul_a = pac_pkg::ESUM_W'(sx_q);
				mul_b = pac_pkg::EDGE_W'(ey_q);
			end
			ST_E1: begin
				mul_a = pac_pkg::ESUM_W'(ex_q);
				mul_b = pac_pkg::EDGE_W'(sy_q);
			end
			ST_E3: begin
				mul_a = xsum_q;
				mul_b = cross_q;
			end
			ST_E4: begin
				mul_a = ysum_q;
				mul_b = cross_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p      = mul_a * mul_b;
	assign cross_next = cross_q - pac_pkg::EDGE_W'(prod_q);

	// A clockwise contour has its sums negated before they join the totals.
	assign c_neg     = ccross_q[pac_pkg::CROSS_W-1];
	assign c_mag     = c_neg ? (~ccross_q + 1'b1) : ccross_q;
	assign area_sum  = (pac_pkg::CROSS_W+1)'(tarea_q) + (pac_pkg::CROSS_W+1)'(c_mag);
	assign cx_signed = c_neg ? (~cx_q + 1'b1) : cx_q;
	assign cy_signed = c_neg ? (~cy_q + 1'b1) : cy_q;

	assign div_req.start   = start_q;
	assign div_req.sum     = div_sum_q;
	assign div_req.divisor = div_den_q;

	pac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			sx_q         <= '0;
			sy_q         <= '0;
			ex_q         <= '0;
			ey_q         <= '0;
			in_contour_q <= 1'b0;
			end_q        <= 1'b0;
			shape_q      <= 1'b0;
			closing_q    <= 1'b0;
			cross_q      <= '0;
			xsum_q       <= '0;
			ysum_q       <= '0;
			prod_q       <= '0;
			ccross_q     <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			tarea_q      <= '0;
			tx_q         <= '0;
			ty_q         <= '0;
			start_q      <= 1'b0;
			div_sum_q    <= '0;
			div_den_q    <= '0;
			cen_x_q      <= '0;
			cen_y_q      <= '0;
			degen_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_area_q   <= '0;
			out_cx_q     <= '0;
			out_cy_q     <= '0;
			out_degen_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (vtx.valid) begin
						prev_x_q  <= vtx.vertex_x;
						prev_y_q  <= vtx.vertex_y;
						end_q     <= vtx.contour_end | vtx.shape_end;
						shape_q   <= vtx.shape_end;
						ex_q      <= vtx.vertex_x;
						ey_q      <= vtx.vertex_y;
						if (in_contour_q) begin
							sx_q      <= prev_x_q;
							sy_q      <= prev_y_q;
							closing_q <= 1'b0;
							state_q   <= ST_E0;
						end else begin
							first_x_q    <= vtx.vertex_x;
							first_y_q    <= vtx.vertex_y;
							in_contour_q <= 1'b1;
							// A lone vertex still runs its closing edge, which adds zero.
							if (vtx.contour_end || vtx.shape_end) begin
								sx_q      <= vtx.vertex_x;
								sy_q      <= vtx.vertex_y;
								closing_q <= 1'b1;
								state_q   <= ST_E0;
							end
						end
					end
				end
				ST_E0: begin
					prod_q  <= mul_p;
					state_q <= ST_E1;
				end
				ST_E1: begin
					cross_q <= pac_pkg::EDGE_W'(prod_q);
					prod_q  <= mul_p;
					state_q <= ST_E2;
				end
				ST_E2: begin
					cross_q  <= cross_next;
					ccross_q <= ccross_q + pac_pkg::CROSS_W'(cross_next);
					xsum_q   <= pac_pkg::ESUM_W'(ex_q) + pac_pkg::ESUM_W'(sx_q);
					ysum_q   <= pac_pkg::ESUM_W'(ey_q) + pac_pkg::ESUM_W'(sy_q);
					state_q  <= ST_E3;
				end
				ST_E3: begin
					prod_q  <= mul_p;
					state_q <= ST_E4;
				end
				ST_E4: begin
					cx_q    <= cx_q + pac_pkg::SUM_W'(prod_q);
					prod_q  <= mul_p;
					state_q <= ST_E5;
				end
				ST_E5: begin
					cy_q <= cy_q + pac_pkg::SUM_W'(prod_q);
					if (!closing_q && end_q) begin
						sx_q      <= ex_q;
						sy_q      <= ey_q;
						ex_q      <= first_x_q;
						ey_q      <= first_y_q;
						closing_q <= 1'b1;
						state_q   <= ST_E0;
					end else if (closing_q) begin
						state_q <= ST_CLOSE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLOSE: begin
					tarea_q      <= (area_sum > (pac_pkg::CROSS_W+1)'(pac_pkg::AREA_MAX)) ?
						pac_pkg::AREA_MAX : area_sum[pac_pkg::AREA_W-1:0];
					tx_q         <= tx_q + cx_signed;
					ty_q         <= ty_q + cy_signed;
					ccross_q     <= '0;
					cx_q         <= '0;
					cy_q         <= '0;
					in_contour_q <= 1'b0;
					state_q      <= shape_q ? ST_SETUP : ST_IDLE;
				end
				ST_SETUP: begin
					// The divisor is three times twice-area, that is six times the area.
					div_den_q <= {1'b0, tarea_q, 1'b0} + pac_pkg::CROSS_W'(tarea_q);
					if (tarea_q == '0) begin
						cen_x_q <= '0;
						cen_y_q <= '0;
						degen_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						degen_q   <= 1'b0;
						div_sum_q <= tx_q;
						start_q   <= 1'b1;
						state_q   <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (div_rsp.done) begin
						cen_x_q   <= div_rsp.quo;
						div_sum_q <= ty_q;
						start_q   <= 1'b1;
						state_q   <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_rsp.done) begin
						cen_y_q <= div_rsp.quo;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_area_q  <= tarea_q;
						out_cx_q    <= cen_x_q;
						out_cy_q    <= cen_y_q;
						out_degen_q <= degen_q;
						tarea_q     <= '0;
						tx_q        <= '0;
						ty_q        <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign vtx.ready      = (state_q == ST_IDLE);
	assign res.valid      = out_valid_q;
	assign res.area_twice = out_area_q;
	assign res.centroid_x = out_cx_q;
	assign res.centroid_y = out_cy_q;
	assign res.degenerate = out_degen_q;

	a_degen_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.degenerate == (res.area_twice == '0)))
		else $error("degenerate flag disagrees with area");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.degenerate) |-> (res.centroid_x == '0 && res.centroid_y == '0))
		else $error("degenerate result carries a nonzero centroid");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVX || state_q == ST_DIVY))
		else $error("divider finished outside a divide phase");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE) |=> (!in_contour_q && ccross_q == '0))
		else $error("contour state not cleared after close");

endmodule
